// ===== rtl/core/psa_pkg.sv =====
// Shared widths, reset values, register indexes and records of the power statistics block.
package psa_pkg;

	localparam int CUR_W       = 20;
	localparam int VOLT_W      = 13;
	localparam int MODE_W      = 3;
	localparam int POWER_W     = 33;
	localparam int CNT_W       = 32;
	localparam int TIME_W      = 32;
	localparam int ENERGY_W    = 64;
	localparam int SUM_W       = 52;
	localparam int RUNTIME_W   = 34;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int TICK_W      = POWER_W + CFG_W;
	localparam int SCALE_W     = 18;
	localparam int DVS_W       = 32;
	localparam int DVD_W       = RUNTIME_W;
	localparam int STEP_W      = 6;

	localparam int NUM_MODES_DEF = 5;

	localparam logic [CFG_W-1:0]   CAP_RESET      = 16'd2000;
	localparam logic [CFG_W-1:0]   INTERVAL_RESET = 16'd100;
	localparam logic [SCALE_W-1:0] Q8_HOUR_SCALE  = 18'd256000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BATTERY_CAPACITY = 2'd0,
		CFG_SAMPLE_INTERVAL  = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy;
		logic [TIME_W-1:0]   time_ms;
		logic [CNT_W-1:0]    count;
	} mode_rec_t;

	typedef struct packed {
		logic [POWER_W-1:0]   power_nw;
		logic [CNT_W-1:0]     sample_total;
		logic [CUR_W-1:0]     avg_current_ua;
		logic [CUR_W-1:0]     peak_current_ua;
		logic [CUR_W-1:0]     min_current_ua;
		logic [ENERGY_W-1:0]  total_energy_pj;
		logic [RUNTIME_W-1:0] runtime_hours_q8;
		logic                 runtime_valid;
		logic [CNT_W-1:0]     mode_sample_count;
		logic [TIME_W-1:0]    mode_elapsed_ms;
		logic [ENERGY_W-1:0]  mode_energy_pj;
	} result_t;

endpackage

// ===== rtl/core/psa_if.sv =====
// Sample and result channel interfaces of the power statistics block.
interface psa_sample_if;
	import psa_pkg::*;
	logic              valid;
	logic              ready;
	logic [CUR_W-1:0]  current_ua;
	logic [VOLT_W-1:0] supply_mv;
	logic [MODE_W-1:0] power_mode;

	modport source (output valid, output current_ua, output supply_mv, output power_mode,
		input ready);
	modport sink (input valid, input current_ua, input supply_mv, input power_mode,
		output ready);
endinterface

interface psa_result_if;
	import psa_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [POWER_W-1:0]   power_nw;
	logic [CNT_W-1:0]     sample_total;
	logic [CUR_W-1:0]     avg_current_ua;
	logic [CUR_W-1:0]     peak_current_ua;
	logic [CUR_W-1:0]     min_current_ua;
	logic [ENERGY_W-1:0]  total_energy_pj;
	logic [RUNTIME_W-1:0] runtime_hours_q8;
	logic                 runtime_valid;
	logic [CNT_W-1:0]     mode_sample_count;
	logic [TIME_W-1:0]    mode_elapsed_ms;
	logic [ENERGY_W-1:0]  mode_energy_pj;

	modport source (output valid, output power_nw, output sample_total,
		output avg_current_ua, output peak_current_ua, output min_current_ua,
		output total_energy_pj, output runtime_hours_q8, output runtime_valid,
		output mode_sample_count, output mode_elapsed_ms, output mode_energy_pj,
		input ready);
	modport sink (input valid, input power_nw, input sample_total,
		input avg_current_ua, input peak_current_ua, input min_current_ua,
		input total_energy_pj, input runtime_hours_q8, input runtime_valid,
		input mode_sample_count, input mode_elapsed_ms, input mode_energy_pj,
		output ready);
endinterface

// ===== rtl/core/power_statistics_accumulator.sv =====
// Power statistics block: per-sample power, energy, per-mode and overall statistics.
//
// Usage: each word on the sample channel is one sample tick (current, voltage,
// power mode). For every accepted sample exactly one word appears on the result
// channel, carrying power, overall totals, mean, peak and minimum current, the
// battery runtime prediction and the accumulators of the sample's own mode.
// Both channels use valid/ready; a word moves on an edge where both are high.
// The configuration port writes battery capacity (index 0) and sample interval
// (index 1); other indexes are ignored. The user must write them only while the
// block is idle; the block itself does not enforce this.
// One sample is worked at a time. From acceptance to result valid it passes the
// states MUL, ENG, UPD, DIV1, RLOAD, DIV2 and OUT, using the shared restoring
// divider: 20 steps for the mean current and 34 steps for the runtime. When the
// mean saturates the first pass is skipped, and when the mean is zero the second
// pass is skipped; the next sample is taken once the result register is loaded.
// The per-mode accumulators live in a small RAM with one valid bit per mode.
// Reset clears all statistics, the valid bits and the configuration to its
// defaults at once; no clearing pass is needed. A stalled receiver holds the
// result word; a finished sample waits in the final state until it can be
// loaded, and no new sample is taken meanwhile.
module power_statistics_accumulator #(
	parameter int NUM_MODES = psa_pkg::NUM_MODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [psa_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [psa_pkg::CFG_W-1:0]      cfg_data,
	psa_sample_if.sink                     sample,
	psa_result_if.source                   result
);
	import psa_pkg::*;

	localparam int AW    = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
	localparam int EXT_W = AW + MODE_W;
	localparam int REC_W = $bits(mode_rec_t);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_ENG, S_UPD, S_DIV1, S_RLOAD, S_DIV2, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [CFG_W-1:0] cap_q, intv_q;

	// captured sample
	logic [CUR_W-1:0]  cur_q;
	logic [VOLT_W-1:0] volt_q;
	logic [AW-1:0]     addr_q;
	logic              inr_q;

	// working values
	logic [POWER_W-1:0]  power_q;
	logic [TICK_W-1:0]   energy_q;
	logic [DVD_W-1:0]    num_q;
	logic [CNT_W-1:0]    mode_cnt_q;
	logic [TIME_W-1:0]   mode_time_q;
	logic [ENERGY_W-1:0] mode_eng_q;

	// overall statistics
	logic [CNT_W-1:0]     samples_q;
	logic [SUM_W-1:0]     csum_q;
	logic [ENERGY_W-1:0]  esum_q;
	logic [CUR_W-1:0]     peak_q, min_q, avg_q;
	logic [RUNTIME_W-1:0] rt_q;
	logic                 rt_ok_q;
	logic [NUM_MODES-1:0] vld_q;

	// divider
	logic [DVS_W-1:0]  rem_q, dvs_q;
	logic [DVD_W-1:0]  dvd_q, quo_q;
	logic [STEP_W-1:0] cnt_q;

	// result register
	result_t res_q;
	logic    res_vld_q;

	logic                 accept;
	logic [EXT_W-1:0]     in_mode_ext;
	logic [AW-1:0]        in_addr;
	logic                 in_inr;
	logic [REC_W-1:0]     ram_rdata;
	mode_rec_t            rec_old, rec_new;
	logic [TIME_W:0]      time_sum;
	logic [ENERGY_W:0]    eng_sum, esum_sum;
	logic [SUM_W:0]       csum_sum;
	logic                 avg_ovf;
	logic [DVS_W:0]       rem_sh, rem_diff;
	logic                 div_ge;
	logic [DVS_W-1:0]     rem_nx;
	logic [DVD_W-1:0]     quo_nx;
	logic                 res_load;

	assign accept       = sample.valid && sample.ready;
	assign sample.ready = (state_q == S_IDLE);

	// mode to RAM address; modes beyond the table touch nothing
	assign in_mode_ext = {{AW{1'b0}}, sample.power_mode};
	assign in_addr     = in_mode_ext[AW-1:0];
	assign in_inr      = (in_mode_ext < EXT_W'(NUM_MODES));

	psa_ram #(
		.WIDTH (REC_W),
		.DEPTH (NUM_MODES)
	) u_mode_ram (
		.clk   (clk),
		.we    ((state_q == S_UPD) && inr_q),
		.waddr (addr_q),
		.wdata (rec_new),
		.re    (accept && in_inr),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	// an entry never written since reset reads as zero
	assign rec_old = (inr_q && vld_q[addr_q]) ? mode_rec_t'(ram_rdata) : '0;

	// saturating per-mode update
	assign time_sum = {1'b0, rec_old.time_ms} + (TIME_W+1)'(intv_q);
	assign eng_sum  = {1'b0, rec_old.energy} + (ENERGY_W+1)'(energy_q);
	always_comb begin
		rec_new.count   = (rec_old.count == '1) ? rec_old.count : rec_old.count + 1'b1;
		rec_new.time_ms = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
		rec_new.energy  = eng_sum[ENERGY_W] ? '1 : eng_sum[ENERGY_W-1:0];
	end

	assign esum_sum = {1'b0, esum_q} + (ENERGY_W+1)'(energy_q);
	assign csum_sum = {1'b0, csum_q} + (SUM_W+1)'(cur_q);

	// mean saturates when the top bits already reach the count
	assign avg_ovf = (csum_q[SUM_W-1:CUR_W] >= samples_q);

	// one restoring step of the shared divider
	assign rem_sh   = {rem_q, dvd_q[DVD_W-1]};
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign div_ge   = (rem_sh >= {1'b0, dvs_q});
	assign rem_nx   = div_ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
	assign quo_nx   = {quo_q[DVD_W-2:0], div_ge};

	assign res_load = (state_q == S_OUT) && (!res_vld_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			intv_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_BATTERY_CAPACITY) begin
				cap_q <= cfg_data;
			end else if (cfg_idx == CFG_SAMPLE_INTERVAL) begin
				intv_q <= cfg_data;
			end
		end
	end

	// sequencer, statistics and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_vld_q <= 1'b0;
			samples_q <= '0;
			csum_q    <= '0;
			esum_q    <= '0;
			peak_q    <= '0;
			min_q     <= '0;
			avg_q     <= '0;
			rt_q      <= '0;
			rt_ok_q   <= 1'b0;
			vld_q     <= '0;
		end else begin
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					samples_q <= (samples_q == '1) ? samples_q : samples_q + 1'b1;
					csum_q    <= csum_sum[SUM_W] ? '1 : csum_sum[SUM_W-1:0];
					if (cur_q > peak_q) begin
						peak_q <= cur_q;
					end
					// first sample sets the minimum outright
					if ((samples_q == '0) || (cur_q < min_q)) begin
						min_q <= cur_q;
					end
					state_q <= S_ENG;
				end
				S_ENG: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					esum_q <= esum_sum[ENERGY_W] ? '1 : esum_sum[ENERGY_W-1:0];
					if (inr_q) begin
						vld_q[addr_q] <= 1'b1;
					end
					if (avg_ovf) begin
						avg_q   <= '1;
						state_q <= S_RLOAD;
					end else begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (cnt_q == '0) begin
						avg_q   <= quo_nx[CUR_W-1:0];
						state_q <= S_RLOAD;
					end
				end
				S_RLOAD: begin
					state_q <= (avg_q != '0) ? S_DIV2 : S_OUT;
				end
				S_DIV2: begin
					if (cnt_q == '0) begin
						rt_q    <= quo_nx;
						rt_ok_q <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= sample.current_ua;
			volt_q <= sample.supply_mv;
			addr_q <= in_addr;
			inr_q  <= in_inr;
		end
		if (state_q == S_MUL) begin
			power_q <= POWER_W'(cur_q) * POWER_W'(volt_q);
		end
		if (state_q == S_ENG) begin
			energy_q <= TICK_W'(power_q) * TICK_W'(intv_q);
			num_q    <= DVD_W'(cap_q) * DVD_W'(Q8_HOUR_SCALE);
		end
		if (state_q == S_UPD) begin
			mode_cnt_q  <= inr_q ? rec_new.count : '0;
			mode_time_q <= inr_q ? rec_new.time_ms : '0;
			mode_eng_q  <= inr_q ? rec_new.energy : '0;
			// load the mean division: high bits of the sum start as the remainder
			rem_q <= csum_q[SUM_W-1:CUR_W];
			dvd_q <= {csum_q[CUR_W-1:0], {(DVD_W-CUR_W){1'b0}}};
			dvs_q <= samples_q;
			quo_q <= '0;
			cnt_q <= STEP_W'(CUR_W - 1);
		end
		if ((state_q == S_DIV1) || (state_q == S_DIV2)) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= quo_nx;
			cnt_q <= cnt_q - 1'b1;
		end
		if (state_q == S_RLOAD) begin
			rem_q <= '0;
			dvd_q <= num_q;
			dvs_q <= DVS_W'(avg_q);
			quo_q <= '0;
			cnt_q <= STEP_W'(DVD_W - 1);
		end
		if (res_load) begin
			res_q.power_nw          <= power_q;
			res_q.sample_total      <= samples_q;
			res_q.avg_current_ua    <= avg_q;
			res_q.peak_current_ua   <= peak_q;
			res_q.min_current_ua    <= min_q;
			res_q.total_energy_pj   <= esum_q;
			res_q.runtime_hours_q8  <= rt_q;
			res_q.runtime_valid     <= rt_ok_q;
			res_q.mode_sample_count <= mode_cnt_q;
			res_q.mode_elapsed_ms   <= mode_time_q;
			res_q.mode_energy_pj    <= mode_eng_q;
		end
	end

	assign result.valid             = res_vld_q;
	assign result.power_nw          = res_q.power_nw;
	assign result.sample_total      = res_q.sample_total;
	assign result.avg_current_ua    = res_q.avg_current_ua;
	assign result.peak_current_ua   = res_q.peak_current_ua;
	assign result.min_current_ua    = res_q.min_current_ua;
	assign result.total_energy_pj   = res_q.total_energy_pj;
	assign result.runtime_hours_q8  = res_q.runtime_hours_q8;
	assign result.runtime_valid     = res_q.runtime_valid;
	assign result.mode_sample_count = res_q.mode_sample_count;
	assign result.mode_elapsed_ms   = res_q.mode_elapsed_ms;
	assign result.mode_energy_pj    = res_q.mode_energy_pj;

endmodule

// ===== rtl/core/psa_ram.sv =====
// Generic single-port-write, registered-read RAM.
module psa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/psa_checker.sv =====
// Port-level checks of the power statistics block and their binding.
module psa_checker (
	input logic          clk,
	input logic          arst_n,
	psa_sample_if.sink   sample,
	psa_result_if.source result
);

	// hold a stalled result word
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.sample_total)
		&& $stable(result.power_nw))
		else $error("result word changed while stalled");

	// one sample at a time: drop ready after a sample is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("sample taken while another is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.min_current_ua <= result.peak_current_ua)
		else $error("minimum current above peak");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.avg_current_ua != '0) |-> result.runtime_valid)
		else $error("nonzero mean without runtime prediction");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.sample_total != '0)
		else $error("result with zero sample total");

endmodule

bind power_statistics_accumulator psa_checker u_psa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.sample (sample),
	.result (result)
);

// ===== test/testbench.sv =====
// Self-checking testbench of the power statistics block, with a scoreboard and random traffic.
module testbench;
	import psa_pkg::*;

	localparam int MODES       = NUM_MODES_DEF;
	localparam int MODE_CODES  = 1 << MODE_W;
	localparam int PHASES      = 9;
	localparam int RANDOM_ITEMS = 175;
	localparam int HOLD_CYCLES = 500;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 120;

	localparam logic [63:0] CUR_TOP    = (64'd1 << CUR_W) - 1;
	localparam logic [63:0] CNT_TOP    = (64'd1 << CNT_W) - 1;
	localparam logic [63:0] SUM_TOP    = (64'd1 << SUM_W) - 1;
	localparam logic [63:0] ENERGY_TOP = '1;

	// register indexes past the end of the map; writes to them must leave no trace
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	// Statistics predictor and store of expected result words.
	class meter_scoreboard;
		logic [CFG_W-1:0]     cap_mah;
		logic [CFG_W-1:0]     tick_ms;
		logic [CNT_W-1:0]     mode_cnt [MODES];
		logic [TIME_W-1:0]    mode_ms [MODES];
		logic [ENERGY_W-1:0]  mode_pj [MODES];
		logic [CNT_W-1:0]     n_samples;
		logic [SUM_W-1:0]     cur_total;
		logic [ENERGY_W-1:0]  pj_total;
		logic [CUR_W-1:0]     cur_max;
		logic [CUR_W-1:0]     cur_min;
		logic [RUNTIME_W:0]   runtime_q8;
		logic                 runtime_set;
		result_t              expected_stats [$];
		int                   errors;

		function new();
			cap_mah = CAP_RESET;
			tick_ms = INTERVAL_RESET;
			for (int m = 0; m < MODES; m++) begin
				mode_cnt[m] = '0;
				mode_ms[m]  = '0;
				mode_pj[m]  = '0;
			end
			n_samples   = '0;
			cur_total   = '0;
			pj_total    = '0;
			cur_max     = '0;
			cur_min     = '0;
			runtime_q8  = '0;
			runtime_set = 1'b0;
			errors      = 0;
		endfunction

		function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] top);
			logic [64:0] s;
			s = {1'b0, a} + {1'b0, b};
			if (s > {1'b0, top})
				return top;
			return s[63:0];
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			unique case (idx)
				CFG_BATTERY_CAPACITY: cap_mah = data;
				CFG_SAMPLE_INTERVAL:  tick_ms = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_stats.size();
		endfunction

		// Advance the statistics by one sample tick and queue the word it must produce.
		function void note_sample(logic [CUR_W-1:0] cur, logic [VOLT_W-1:0] volt,
				logic [MODE_W-1:0] mode);
			result_t              want;
			logic [POWER_W-1:0]   pwr;
			logic [ENERGY_W-1:0]  tick_pj;
			logic [SUM_W-1:0]     quot;
			logic [CUR_W-1:0]     avg;
			logic [63:0]          scaled;
			bit                   first;
			pwr     = POWER_W'(cur) * POWER_W'(volt);
			tick_pj = ENERGY_W'(pwr) * ENERGY_W'(tick_ms);
			first   = (n_samples == '0);
			want    = '0;
			if (int'(mode) < MODES) begin
				mode_cnt[mode] = CNT_W'(sat_sum(64'(mode_cnt[mode]), 64'd1, CNT_TOP));
				mode_ms[mode]  = TIME_W'(sat_sum(64'(mode_ms[mode]), 64'(tick_ms), CNT_TOP));
				mode_pj[mode]  = sat_sum(mode_pj[mode], tick_pj, ENERGY_TOP);
				want.mode_sample_count = mode_cnt[mode];
				want.mode_elapsed_ms   = mode_ms[mode];
				want.mode_energy_pj    = mode_pj[mode];
			end
			n_samples = CNT_W'(sat_sum(64'(n_samples), 64'd1, CNT_TOP));
			pj_total  = sat_sum(pj_total, tick_pj, ENERGY_TOP);
			cur_total = SUM_W'(sat_sum(64'(cur_total), 64'(cur), SUM_TOP));
			quot = cur_total / n_samples;
			if (64'(quot) > CUR_TOP)
				avg = '1;
			else
				avg = quot[CUR_W-1:0];
			if (cur > cur_max)
				cur_max = cur;
			if (first || cur < cur_min)
				cur_min = cur;
			if (avg != '0) begin
				scaled      = 64'(cap_mah) * 64'(Q8_HOUR_SCALE);
				runtime_q8  = (RUNTIME_W+1)'(scaled / 64'(avg));
				runtime_set = 1'b1;
			end
			want.power_nw         = pwr;
			want.sample_total     = n_samples;
			want.avg_current_ua   = avg;
			want.peak_current_ua  = cur_max;
			want.min_current_ua   = cur_min;
			want.total_energy_pj  = pj_total;
			want.runtime_hours_q8 = runtime_q8[RUNTIME_W-1:0];
			want.runtime_valid    = runtime_set;
			expected_stats.push_back(want);
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_stats.size() == 0) begin
				$error("result word with no sample outstanding");
				errors++;
				return;
			end
			want = expected_stats.pop_front();
			compare("power_nw", 64'(want.power_nw), 64'(got.power_nw));
			compare("sample_total", 64'(want.sample_total), 64'(got.sample_total));
			compare("avg_current_ua", 64'(want.avg_current_ua), 64'(got.avg_current_ua));
			compare("peak_current_ua", 64'(want.peak_current_ua), 64'(got.peak_current_ua));
			compare("min_current_ua", 64'(want.min_current_ua), 64'(got.min_current_ua));
			compare("total_energy_pj", want.total_energy_pj, got.total_energy_pj);
			compare("runtime_hours_q8", 64'(want.runtime_hours_q8), 64'(got.runtime_hours_q8));
			compare("runtime_valid", 64'(want.runtime_valid), 64'(got.runtime_valid));
			compare("mode_sample_count", 64'(want.mode_sample_count),
				64'(got.mode_sample_count));
			compare("mode_elapsed_ms", 64'(want.mode_elapsed_ms), 64'(got.mode_elapsed_ms));
			compare("mode_energy_pj", want.mode_energy_pj, got.mode_energy_pj);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;
	bit                   calm_phase;
	result_t              seen_word;

	meter_scoreboard meter = new();

	psa_sample_if sample_ch ();
	psa_result_if result_ch ();

	power_statistics_accumulator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.sample   (sample_ch),
		.result   (result_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Idle lengths for both sides: mostly none or short, now and then long enough
	// to cover a whole division pass. A calm phase runs flat out with no idling at all.
	function automatic int pick_gap();
		int r;
		if (calm_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 30);
		return $urandom_range(40, 150);
	endfunction

	// Offer one sample word and hold it until the block takes it. Return at the edge
	// of acceptance with valid still high, so a back-to-back word needs no lowering.
	task automatic send_sample(input logic [CUR_W-1:0] cur, input logic [VOLT_W-1:0] volt,
			input logic [MODE_W-1:0] mode);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.current_ua <= cur;
		sample_ch.supply_mv  <= volt;
		sample_ch.power_mode <= mode;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// Random sample: full-range fields, weighted towards zero, all-ones and small
	// currents, with a share of mode codes past the last real mode.
	task automatic send_random();
		logic [CUR_W-1:0]  cur;
		logic [VOLT_W-1:0] volt;
		logic [MODE_W-1:0] mode;
		int                pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			cur = '0;
		else if (pick < 13)
			cur = '1;
		else if (pick < 25)
			cur = CUR_W'($urandom_range(1, 15));
		else
			cur = CUR_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 5)
			volt = '0;
		else if (pick < 10)
			volt = '1;
		else
			volt = VOLT_W'($urandom);
		if ($urandom_range(0, 99) < 88)
			mode = MODE_W'($urandom_range(0, MODES - 1));
		else
			mode = MODE_W'($urandom_range(MODES, MODE_CODES - 1));
		send_sample(cur, volt, mode);
	endtask

	// Drop valid and wait until every sample taken so far has produced its word.
	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (meter.pending() != 0);
	endtask

	// One register write per cycle; the caller lowers the enable after the last one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Stimulus: reset, a directed opening under the reset configuration, then phases of
	// random samples, each under a new configuration written while the block is idle.
	initial begin : stimulus
		logic [CFG_W-1:0] cap;
		logic [CFG_W-1:0] ivl;
		bit               spare;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_idx              = '0;
		cfg_data             = '0;
		sample_ch.valid      = 1'b0;
		sample_ch.current_ua = '0;
		sample_ch.supply_mv  = '0;
		sample_ch.power_mode = '0;
		calm_phase           = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				wait_drained();
				spare = 1'b0;
				unique case (ph)
					1: begin
						cap = '1;
						ivl = '1;
					end
					2: begin
						// zero capacity: a valid prediction of zero hours
						cap = '0;
						ivl = 16'd1;
					end
					3: begin
						// zero interval: ticks add neither time nor energy
						cap   = CFG_W'($urandom);
						ivl   = '0;
						spare = 1'b1;
					end
					4: begin
						cap = 16'd1;
						ivl = 16'd1;
					end
					7: begin
						cap   = '1;
						ivl   = INTERVAL_RESET;
						spare = 1'b1;
					end
					default: begin
						cap = CFG_W'($urandom);
						ivl = CFG_W'($urandom_range(1, (1 << CFG_W) - 1));
					end
				endcase
				write_reg(CFG_BATTERY_CAPACITY, cap);
				write_reg(CFG_SAMPLE_INTERVAL, ivl);
				if (spare) begin
					write_reg(CFG_SPARE_LO, CFG_W'($urandom));
					write_reg(CFG_SPARE_HI, CFG_W'($urandom));
				end
				cfg_we <= 1'b0;
			end
			calm_phase = (ph == 5);

			if (ph == 0) begin
				// first sample sets the minimum whatever the reset value held
				send_sample(20'd2, 13'd3300, 3'd0);
				send_sample(20'd1, 13'd3300, 3'd1);
				send_sample(20'd0, 13'd8191, 3'd2);
				// mean falls to zero: the prediction must hold its last value
				send_sample(20'd0, 13'd0, 3'd3);
				send_sample(20'd0, 13'd1, 3'd4);
				// largest current and voltage, largest power
				send_sample(20'hFFFFF, 13'h1FFF, 3'd0);
				send_sample(20'hFFFFF, 13'h1FFF, 3'd4);
				// mode codes past the last mode: per-mode fields read zero
				send_sample(20'h55555, 13'h0AAA, 3'd5);
				send_sample(20'hAAAAA, 13'h1555, 3'd6);
				send_sample(20'd12345, 13'd3700, 3'd7);
				send_sample(20'd1, 13'h1FFF, 3'd1);
				send_sample(20'd500000, 13'd1800, 3'd2);
				send_sample(20'd3, 13'd5, 3'd3);
			end
			repeat (RANDOM_ITEMS) send_random();
		end

		wait_drained();
		// keep watching for stray words a while after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (meter.errors == 0 && meter.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: random stalls after each word, plus two long hold-offs during which the
	// sender keeps offering, so the block fills up and back-pressures its input.
	initial begin : receiver
		int stall;
		int taken;
		result_ch.ready = 1'b0;
		taken = 0;
		@(posedge clk);
		forever begin
			if (taken == 400 || taken == 1100)
				stall = HOLD_CYCLES;
			else
				stall = pick_gap();
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			taken++;
		end
	end

	// Monitor: apply register writes to the predictor, check result words against the
	// oldest expectation, then note newly accepted samples.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				meter.set_reg(cfg_idx, cfg_data);
			if (result_ch.valid && result_ch.ready) begin
				seen_word.power_nw          = result_ch.power_nw;
				seen_word.sample_total      = result_ch.sample_total;
				seen_word.avg_current_ua    = result_ch.avg_current_ua;
				seen_word.peak_current_ua   = result_ch.peak_current_ua;
				seen_word.min_current_ua    = result_ch.min_current_ua;
				seen_word.total_energy_pj   = result_ch.total_energy_pj;
				seen_word.runtime_hours_q8  = result_ch.runtime_hours_q8;
				seen_word.runtime_valid     = result_ch.runtime_valid;
				seen_word.mode_sample_count = result_ch.mode_sample_count;
				seen_word.mode_elapsed_ms   = result_ch.mode_elapsed_ms;
				seen_word.mode_energy_pj    = result_ch.mode_energy_pj;
				meter.check_result(seen_word);
			end
			if (sample_ch.valid && sample_ch.ready)
				meter.note_sample(sample_ch.current_ua, sample_ch.supply_mv,
					sample_ch.power_mode);
		end
	end

	// Watchdog: end the run once nothing has moved on any port for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
					|| cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
